@@ rtl/htw_pkg.sv @@
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types, codes and defaults for the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

	localparam int WHEEL_BITS_DEF = 6;
	localparam int LEVELS_DEF     = 4;
	localparam int POOL_SIZE_DEF  = 32;

	// timer link pointers are six bits; all ones ends a list
	localparam int          LINK_W = 6;
	localparam logic [5:0]  NIL    = 6'h3F;

	localparam logic [23:0] M24 = 24'hFF_FFFF;
	localparam logic [31:0] M32 = 32'hFFFF_FFFF;
	localparam logic [39:0] M40 = 40'hFF_FFFF_FFFF;

	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;
	// reserved code, dropped with no result
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_EXPIRY = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_START  = 2'd1;
	localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  timer_id;
		logic [23:0] interval_ticks;
		logic        repeat_req;
	} htw_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [4:0]  fired_id;
		logic [23:0] elapsed_ms;
		logic [23:0] drift_ms;
		logic [31:0] call_count;
		logic [23:0] min_seen;
		logic [23:0] max_seen;
		logic [31:0] timer_drift_sum;
		logic [39:0] all_drift_sum;
		logic [5:0]  active_count;
		logic        last;
	} htw_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LK_CALC,
		S_LK_RD,
		S_LK_WR,
		S_ACK,
		S_CX_RD,
		S_CX_HEAD,
		S_CX_NODE,
		S_TICK_CHK,
		S_CAS_RD,
		S_CAS_HEAD,
		S_CAS_NODE,
		S_FIRE_RD,
		S_FIRE_HEAD,
		S_FIRE_NODE,
		S_FIRE_CALC,
		S_FIRE_UPD,
		S_END
	} htw_state_t;

endpackage

@@ rtl/hierarchical_timer_wheel_top.sv @@
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top
// Four-level hashed timer wheel over a fixed timer pool, one tick per ms.
// ----------------------------------------------------------------------------
// Usage:
//   A request is transferred on req when start is high and busy is low.
//   Start and cancel requests give one acknowledge; a tick request gives one
//   expiry per timer firing in the current slot, then an end-of-tick result.
//   Each result sits on rsp for one cycle with rsp_strobe high; the receiver
//   cannot stall, it must take every strobed result. rsp.last marks the
//   final result of a request. Request code 3 is dropped with no result.
// Operation:
//   Every link runs through one shared link unit; all list work uses one
//   slot-head memory with registered read. Start finds the slot, reads its
//   head and writes the new head, then acknowledges. Cancel walks the slot
//   list entry by entry. Tick cascades each due level, re-linking its timers,
//   then fires each timer in the current slot, re-linking those that re-arm.
//   busy is high from transfer until the last result is loaded.
// Reset:
//   arst_n clears all lists, flags, statistics and time at once; slot heads
//   carry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top #(
	parameter int WHEEL_BITS = htw_pkg::WHEEL_BITS_DEF,
	parameter int LEVELS     = htw_pkg::LEVELS_DEF,
	parameter int POOL_SIZE  = htw_pkg::POOL_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  htw_pkg::htw_req_t req,
	output logic             rsp_strobe,
	output htw_pkg::htw_rsp_t rsp
);
	import htw_pkg::*;

	localparam int LVW   = $clog2(LEVELS);
	localparam int SIW   = LVW + WHEEL_BITS;
	localparam int DEPTH = LEVELS << WHEEL_BITS;
	localparam int PIW   = $clog2(POOL_SIZE);
	localparam int CNW   = $clog2(LEVELS + 1);
	localparam logic [32:0] SPAN = (33'd1 << (WHEEL_BITS * LEVELS)) - 33'd1;
	localparam logic [5:0]  POOL6 = 6'(POOL_SIZE);

	htw_state_t state_q, state_d, ret_q;

	// slot head memory
	logic [5:0]     slot_mem [DEPTH];
	logic           slot_vld_q [DEPTH];
	logic [5:0]     rd_data_q;
	logic           rd_vld_q;
	logic [SIW-1:0] rd_addr, slot_wa;
	logic [5:0]     slot_wd;
	logic           slot_we;
	logic [5:0]     head;

	// per-timer stores
	logic [5:0]     next_q  [POOL_SIZE];
	logic [SIW-1:0] tslot_q [POOL_SIZE];
	logic [31:0]    dl_q    [POOL_SIZE];
	logic [31:0]    arm_q   [POOL_SIZE];
	logic [23:0]    ivl_q   [POOL_SIZE];
	logic           rep_q   [POOL_SIZE];
	logic           act_q   [POOL_SIZE];
	logic [31:0]    cnt_q   [POOL_SIZE];
	logic [23:0]    min_q   [POOL_SIZE];
	logic [23:0]    max_q   [POOL_SIZE];
	logic [31:0]    dsum_q  [POOL_SIZE];

	logic [31:0]    now_q;
	logic [5:0]     armed_q;
	logic [39:0]    gdrift_q;

	// sequencer registers
	htw_req_t       req_q;
	logic [1:0]     st_q;
	logic [5:0]     cur_q, prev_q, fid_q, lid_q;
	logic [SIW-1:0] lk_tgt_q, walk_q;
	logic [CNW-1:0] lvl_q;
	logic [23:0]    el_q, dr_q;
	htw_rsp_t       rsp_q;
	logic           strobe_q;

	// combinational helpers
	logic [5:0]     id6, qid6;
	logic [PIW-1:0] id_ix, qid_ix, cur_ix, fid_ix, lid_ix, prev_ix;
	logic           in_id_ok, q_id_ok, in_act, in_bad, cur_ok;
	logic [23:0]    iv_c;
	logic [5:0]     nxt_cur;
	logic [31:0]    lk_dl, lk_delta;
	logic [LVW-1:0] lk_lv;
	logic [WHEEL_BITS-1:0] lk_field, pf, cf;
	logic [SIW-1:0] lk_tgt;
	logic           cas_go;
	logic [31:0]    e32;
	logic [23:0]    el_c, dr_c, iv_f;
	logic [31:0]    cnt_n, dsum_n;
	logic [32:0]    dsum_w;
	logic [23:0]    min_n, max_n;
	logic [40:0]    gsum_w;
	logic [39:0]    gdrift_n;

	always_comb begin
		id6     = {1'b0, req.timer_id};
		qid6    = {1'b0, req_q.timer_id};
		id_ix   = id6[PIW-1:0];
		qid_ix  = qid6[PIW-1:0];
		cur_ix  = cur_q[PIW-1:0];
		fid_ix  = fid_q[PIW-1:0];
		lid_ix  = lid_q[PIW-1:0];
		prev_ix = prev_q[PIW-1:0];
		in_id_ok = id6 < POOL6;
		q_id_ok  = qid6 < POOL6;
		in_act   = in_id_ok ? act_q[id_ix] : 1'b0;
		in_bad   = !in_id_ok || (req.interval_ticks == 24'd0) || in_act;
		iv_c     = ({9'd0, req.interval_ticks} > SPAN) ? SPAN[23:0] : req.interval_ticks;
		cur_ok   = cur_q < POOL6;
		nxt_cur  = cur_ok ? next_q[cur_ix] : NIL;
		head     = rd_vld_q ? rd_data_q : NIL;
	end

	// link unit: level and slot from the deadline of the timer being linked
	always_comb begin
		lk_dl    = dl_q[lid_ix];
		lk_delta = lk_dl - now_q;
		lk_lv    = LVW'(LEVELS - 1);
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if ((lk_delta >> (WHEEL_BITS * (l + 1))) == 32'd0)
				lk_lv = LVW'(l);
		end
		lk_field = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lk_lv == LVW'(l))
				lk_field = WHEEL_BITS'(lk_dl >> (WHEEL_BITS * l));
		end
		lk_tgt = {lk_lv, lk_field};
	end

	// cascade test: previous wheel has wrapped to zero
	always_comb begin
		pf = '0;
		cf = '0;
		for (int l = 1; l < LEVELS; l++) begin
			if (lvl_q == CNW'(l)) begin
				pf = WHEEL_BITS'(now_q >> (WHEEL_BITS * (l - 1)));
				cf = WHEEL_BITS'(now_q >> (WHEEL_BITS * l));
			end
		end
		cas_go = (lvl_q < CNW'(LEVELS)) && (pf == '0);
	end

	// expiry arithmetic
	always_comb begin
		e32      = now_q - arm_q[fid_ix];
		el_c     = (e32 > {8'd0, M24}) ? M24 : e32[23:0];
		iv_f     = ivl_q[fid_ix];
		dr_c     = (el_c >= iv_f) ? el_c - iv_f : iv_f - el_c;
		cnt_n    = (cnt_q[fid_ix] == M32) ? M32 : cnt_q[fid_ix] + 32'd1;
		min_n    = ((min_q[fid_ix] == 24'd0) || (el_q < min_q[fid_ix])) ?
		           el_q : min_q[fid_ix];
		max_n    = (el_q > max_q[fid_ix]) ? el_q : max_q[fid_ix];
		dsum_w   = {1'b0, dsum_q[fid_ix]} + {9'd0, dr_q};
		dsum_n   = dsum_w[32] ? M32 : dsum_w[31:0];
		gsum_w   = {1'b0, gdrift_q} + {17'd0, dr_q};
		gdrift_n = gsum_w[40] ? M40 : gsum_w[39:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.req_type)
						REQ_START:  state_d = in_bad ? S_ACK : S_LK_CALC;
						REQ_CANCEL: state_d = in_act ? S_CX_RD : S_ACK;
						REQ_TICK:   state_d = S_TICK_CHK;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_LK_CALC:   state_d = S_LK_RD;
			S_LK_RD:     state_d = S_LK_WR;
			S_LK_WR:     state_d = ret_q;
			S_ACK:       state_d = S_IDLE;
			S_CX_RD:     state_d = S_CX_HEAD;
			S_CX_HEAD:   state_d = S_CX_NODE;
			S_CX_NODE:   state_d = (!cur_ok || cur_q == qid6) ? S_ACK : S_CX_NODE;
			S_TICK_CHK:  state_d = cas_go ? S_CAS_RD : S_FIRE_RD;
			S_CAS_RD:    state_d = S_CAS_HEAD;
			S_CAS_HEAD:  state_d = S_CAS_NODE;
			S_CAS_NODE:  state_d = cur_ok ? S_LK_CALC : S_TICK_CHK;
			S_FIRE_RD:   state_d = S_FIRE_HEAD;
			S_FIRE_HEAD: state_d = S_FIRE_NODE;
			S_FIRE_NODE: state_d = cur_ok ? S_FIRE_CALC : S_END;
			S_FIRE_CALC: state_d = S_FIRE_UPD;
			S_FIRE_UPD:  state_d = rep_q[fid_ix] ? S_LK_CALC : S_FIRE_NODE;
			S_END:       state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		busy    = state_q != S_IDLE;
		rd_addr = (state_q == S_LK_RD) ? lk_tgt_q : walk_q;
		slot_we = 1'b0;
		slot_wa = walk_q;
		slot_wd = NIL;
		case (state_q)
			S_LK_WR: begin
				slot_we = 1'b1;
				slot_wa = lk_tgt_q;
				slot_wd = lid_q;
			end
			S_CAS_HEAD, S_FIRE_HEAD: slot_we = 1'b1;
			S_CX_NODE: begin
				slot_we = cur_ok && (cur_q == qid6) && (prev_q == NIL);
				slot_wd = next_q[qid_ix];
			end
			default: slot_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[slot_wa] <= slot_wd;
		rd_data_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slot_vld_q[i] <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (slot_we)
				slot_vld_q[slot_wa] <= 1'b1;
			rd_vld_q <= slot_vld_q[rd_addr];
		end
	end

	// control state and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			lvl_q    <= '0;
			now_q    <= '0;
			armed_q  <= '0;
			gdrift_q <= '0;
			strobe_q <= 1'b0;
			for (int i = 0; i < POOL_SIZE; i++) begin
				next_q[i] <= NIL;
				rep_q[i]  <= 1'b0;
				act_q[i]  <= 1'b0;
				cnt_q[i]  <= '0;
				min_q[i]  <= '0;
				max_q[i]  <= '0;
				dsum_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == S_ACK) || (state_q == S_END) || (state_q == S_FIRE_UPD);
			case (state_q)
				S_IDLE: begin
					if (start && req.req_type == REQ_START && !in_bad) begin
						rep_q[id_ix] <= req.repeat_req;
						act_q[id_ix] <= 1'b1;
						armed_q      <= armed_q + 6'd1;
						ret_q        <= S_ACK;
					end
					if (start && req.req_type == REQ_TICK) begin
						now_q <= now_q + 32'd1;
						lvl_q <= CNW'(1);
					end
				end
				S_LK_WR: next_q[lid_ix] <= head;
				S_CX_NODE: begin
					if (!cur_ok || cur_q == qid6) begin
						act_q[qid_ix] <= 1'b0;
						armed_q       <= armed_q - 6'd1;
						if (cur_ok) begin
							if (prev_q != NIL)
								next_q[prev_ix] <= next_q[qid_ix];
							next_q[qid_ix] <= NIL;
						end
					end
				end
				S_CAS_NODE: begin
					if (cur_ok)
						ret_q <= S_CAS_NODE;
					else
						lvl_q <= lvl_q + CNW'(1);
				end
				S_FIRE_UPD: begin
					cnt_q[fid_ix]  <= cnt_n;
					min_q[fid_ix]  <= min_n;
					max_q[fid_ix]  <= max_n;
					dsum_q[fid_ix] <= dsum_n;
					gdrift_q       <= gdrift_n;
					if (rep_q[fid_ix]) begin
						ret_q <= S_FIRE_NODE;
					end else begin
						act_q[fid_ix]  <= 1'b0;
						next_q[fid_ix] <= NIL;
						armed_q        <= armed_q - 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req;
					case (req.req_type)
						REQ_START: begin
							st_q <= in_bad ? ST_BAD_START : ST_OK;
							lid_q <= id6;
							if (!in_bad) begin
								ivl_q[id_ix] <= iv_c;
								arm_q[id_ix] <= now_q;
								dl_q[id_ix]  <= now_q + {8'd0, iv_c};
							end
						end
						REQ_CANCEL: begin
							st_q <= in_act ? ST_OK : ST_NOT_ACTIVE;
							if (in_act)
								walk_q <= tslot_q[id_ix];
						end
						default: st_q <= ST_OK;
					endcase
				end
			end
			S_LK_CALC: lk_tgt_q <= lk_tgt;
			S_LK_WR:   tslot_q[lid_ix] <= lk_tgt_q;
			S_CX_HEAD: begin
				cur_q  <= head;
				prev_q <= NIL;
			end
			S_CX_NODE: begin
				prev_q <= cur_q;
				cur_q  <= nxt_cur;
			end
			S_TICK_CHK: begin
				if (cas_go)
					walk_q <= {LVW'(lvl_q), cf};
				else
					walk_q <= {LVW'(0), now_q[WHEEL_BITS-1:0]};
			end
			S_CAS_HEAD, S_FIRE_HEAD: cur_q <= head;
			S_CAS_NODE: begin
				lid_q <= cur_q;
				cur_q <= nxt_cur;
			end
			S_FIRE_NODE: begin
				fid_q <= cur_q;
				cur_q <= nxt_cur;
			end
			S_FIRE_CALC: begin
				el_q <= el_c;
				dr_q <= dr_c;
			end
			S_FIRE_UPD: begin
				rsp_q.kind            <= KIND_EXPIRY;
				rsp_q.status          <= ST_OK;
				rsp_q.fired_id        <= fid_q[4:0];
				rsp_q.elapsed_ms      <= el_q;
				rsp_q.drift_ms        <= dr_q;
				rsp_q.call_count      <= cnt_n;
				rsp_q.min_seen        <= min_n;
				rsp_q.max_seen        <= max_n;
				rsp_q.timer_drift_sum <= dsum_n;
				rsp_q.all_drift_sum   <= gdrift_n;
				rsp_q.active_count    <= rep_q[fid_ix] ? armed_q : armed_q - 6'd1;
				rsp_q.last            <= 1'b0;
				if (rep_q[fid_ix]) begin
					lid_q         <= fid_q;
					arm_q[fid_ix] <= now_q;
					dl_q[fid_ix]  <= now_q + {8'd0, iv_f};
				end
			end
			S_ACK: begin
				rsp_q.kind            <= KIND_ACK;
				rsp_q.status          <= st_q;
				rsp_q.fired_id        <= req_q.timer_id;
				rsp_q.elapsed_ms      <= '0;
				rsp_q.drift_ms        <= '0;
				rsp_q.call_count      <= q_id_ok ? cnt_q[qid_ix] : '0;
				rsp_q.min_seen        <= q_id_ok ? min_q[qid_ix] : '0;
				rsp_q.max_seen        <= q_id_ok ? max_q[qid_ix] : '0;
				rsp_q.timer_drift_sum <= q_id_ok ? dsum_q[qid_ix] : '0;
				rsp_q.all_drift_sum   <= gdrift_q;
				rsp_q.active_count    <= armed_q;
				rsp_q.last            <= 1'b1;
			end
			S_END: begin
				rsp_q.kind            <= KIND_TICK;
				rsp_q.status          <= ST_OK;
				rsp_q.fired_id        <= '0;
				rsp_q.elapsed_ms      <= '0;
				rsp_q.drift_ms        <= '0;
				rsp_q.call_count      <= '0;
				rsp_q.min_seen        <= '0;
				rsp_q.max_seen        <= '0;
				rsp_q.timer_drift_sum <= '0;
				rsp_q.all_drift_sum   <= gdrift_q;
				rsp_q.active_count    <= armed_q;
				rsp_q.last            <= 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp_strobe = strobe_q;
	assign rsp        = rsp_q;

endmodule

@@ rtl/htw_checker.sv @@
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks on the timer wheel, bound to the top level.
// ----------------------------------------------------------------------------
module htw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input htw_pkg::htw_req_t req,
	input logic              rsp_strobe,
	input htw_pkg::htw_rsp_t rsp
);
	import htw_pkg::*;

	// a transfer with a meaningful code always starts work
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type != REQ_NONE) |=> busy)
		else $error("no work started after request transfer");

	// expiries are never final and come while the tick is still in hand
	a_expiry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && (rsp.kind == KIND_EXPIRY) |-> !rsp.last && busy)
		else $error("expiry marked final or outside a tick");

	a_tick_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && (rsp.kind == KIND_TICK) |-> rsp.last && (rsp.fired_id == 5'd0))
		else $error("bad end-of-tick result");

	// a final result is never followed directly by another result
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.last |=> !rsp_strobe)
		else $error("result straight after final result");

endmodule

bind hierarchical_timer_wheel_top htw_checker u_htw_checker (.*);

@@ sim/tb_hierarchical_timer_wheel_top.sv @@
// ----------------------------------------------------------------------------
// tb_hierarchical_timer_wheel_top
// Drives start, cancel and tick requests into the timer wheel. A behavioural
// copy of the wheel predicts every acknowledge, expiry and end-of-tick result,
// and each strobed result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_hierarchical_timer_wheel_top;
	timeunit 1ns;
	timeprecision 1ps;
	import htw_pkg::*;

	localparam int WB    = 6;
	localparam int LV    = 4;
	localparam int POOL  = 32;
	localparam int SLOTS = 1 << WB;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	htw_req_t req;
	logic     rsp_strobe;
	htw_rsp_t rsp;

	hierarchical_timer_wheel_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .rsp_strobe(rsp_strobe), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// wheel model state
	logic [5:0]  heads [LV*SLOTS];
	logic [5:0]  nxt_of [POOL];
	int unsigned slot_of [POOL];
	logic [31:0] deadline [POOL];
	logic [31:0] armed_at [POOL];
	logic [23:0] ivl_of [POOL];
	logic        rep_of [POOL];
	logic        active [POOL];
	logic [31:0] fires [POOL];
	logic [23:0] min_el [POOL];
	logic [23:0] max_el [POOL];
	logic [31:0] drift_of [POOL];
	logic [31:0] wheel_now;
	logic [5:0]  n_armed;
	logic [39:0] drift_total;

	htw_rsp_t pending_rsp [$];
	int       errs = 0;
	int       n_items = 0, n_fired = 0, n_ticks = 0, n_rsp = 0;
	int       idle_pct = 0;

	function automatic void wheel_link(input int id);
		logic [31:0] delta;
		int          lvl, idx;
		delta = deadline[id] - wheel_now;
		lvl = LV - 1;
		for (int l = LV - 1; l >= 0; l--)
			if (64'(delta) < (64'd1 << (WB * (l + 1)))) lvl = l;
		idx = lvl * SLOTS + ((deadline[id] >> (WB * lvl)) & (SLOTS - 1));
		nxt_of[id] = heads[idx];
		heads[idx] = 6'(id);
		slot_of[id] = idx;
	endfunction

	function automatic void wheel_unlink(input int id);
		int idx, cur, prev;
		idx = slot_of[id];
		cur = heads[idx];
		prev = NIL;
		for (int g = 0; g < POOL && cur < POOL; g++) begin
			if (cur == id) begin
				if (prev == NIL) heads[idx] = nxt_of[id];
				else nxt_of[prev] = nxt_of[id];
				nxt_of[id] = NIL;
				return;
			end
			prev = cur;
			cur = nxt_of[cur];
		end
	endfunction

	function automatic void wheel_cascade(input int lvl);
		int idx, cur, nx;
		idx = lvl * SLOTS + ((wheel_now >> (WB * lvl)) & (SLOTS - 1));
		cur = heads[idx];
		heads[idx] = NIL;
		for (int g = 0; g < POOL && cur < POOL; g++) begin
			nx = nxt_of[cur];
			wheel_link(cur);
			cur = nx;
		end
	endfunction

	function automatic void queue_rsp(input logic [1:0] kind, input logic [1:0] st,
			input int id, input logic [23:0] el, input logic [23:0] dr,
			input bit stats, input bit lst);
		htw_rsp_t r;
		r = '0;
		r.kind = kind;
		r.status = st;
		if (stats) begin
			r.fired_id = id[4:0];
			r.call_count = fires[id];
			r.min_seen = min_el[id];
			r.max_seen = max_el[id];
			r.timer_drift_sum = drift_of[id];
		end
		r.elapsed_ms = el;
		r.drift_ms = dr;
		r.all_drift_sum = drift_total;
		r.active_count = n_armed;
		r.last = lst;
		pending_rsp.push_back(r);
	endfunction

	// updates the model for one transferred request and queues its results
	function automatic void predict_wheel(input htw_req_t q);
		int          id, cur, nx, idx0;
		logic [23:0] iv, dr;
		logic [31:0] el;
		logic [1:0]  st;
		id = q.timer_id;
		iv = q.interval_ticks;
		case (q.req_type)
			REQ_START: begin
				st = ST_OK;
				if (iv == 0 || active[id]) begin
					st = ST_BAD_START;
				end else begin
					ivl_of[id] = iv;
					rep_of[id] = q.repeat_req;
					armed_at[id] = wheel_now;
					deadline[id] = wheel_now + iv;
					active[id] = 1'b1;
					n_armed++;
					wheel_link(id);
				end
				queue_rsp(KIND_ACK, st, id, 0, 0, 1, 1);
			end
			REQ_CANCEL: begin
				st = ST_NOT_ACTIVE;
				if (active[id]) begin
					wheel_unlink(id);
					active[id] = 1'b0;
					n_armed--;
					st = ST_OK;
				end
				queue_rsp(KIND_ACK, st, id, 0, 0, 1, 1);
			end
			REQ_TICK: begin
				wheel_now++;
				for (int l = 1; l < LV; l++) begin
					if (((wheel_now >> (WB * (l - 1))) & (SLOTS - 1)) != 0) break;
					wheel_cascade(l);
				end
				idx0 = wheel_now & (SLOTS - 1);
				cur = heads[idx0];
				heads[idx0] = NIL;
				for (int g = 0; g < POOL && cur < POOL; g++) begin
					nx = nxt_of[cur];
					el = wheel_now - armed_at[cur];
					if (el > M24) el = M24;
					dr = (el[23:0] >= ivl_of[cur]) ? el[23:0] - ivl_of[cur]
						: ivl_of[cur] - el[23:0];
					if (fires[cur] != M32) fires[cur]++;
					if (min_el[cur] == 0 || el[23:0] < min_el[cur]) min_el[cur] = el[23:0];
					if (el[23:0] > max_el[cur]) max_el[cur] = el[23:0];
					drift_of[cur] = (M32 - drift_of[cur] < dr) ? M32 : drift_of[cur] + dr;
					drift_total = (M40 - drift_total < dr) ? M40 : drift_total + dr;
					if (rep_of[cur]) begin
						armed_at[cur] = wheel_now;
						deadline[cur] = wheel_now + ivl_of[cur];
						wheel_link(cur);
					end else begin
						active[cur] = 1'b0;
						nxt_of[cur] = NIL;
						n_armed--;
					end
					queue_rsp(KIND_EXPIRY, ST_OK, cur, el[23:0], dr, 1, 0);
					cur = nx;
				end
				queue_rsp(KIND_TICK, ST_OK, 0, 0, 0, 0, 1);
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		htw_rsp_t e;
		if (arst_n && rsp_strobe) begin
			n_rsp++;
			if (pending_rsp.size() == 0) begin
				$error("result with nothing expected (kind %0d)", rsp.kind);
				errs++;
			end else begin
				e = pending_rsp.pop_front();
				check_field("kind", e.kind, rsp.kind);
				check_field("status", e.status, rsp.status);
				check_field("fired_id", e.fired_id, rsp.fired_id);
				check_field("elapsed_ms", e.elapsed_ms, rsp.elapsed_ms);
				check_field("drift_ms", e.drift_ms, rsp.drift_ms);
				check_field("call_count", e.call_count, rsp.call_count);
				check_field("min_seen", e.min_seen, rsp.min_seen);
				check_field("max_seen", e.max_seen, rsp.max_seen);
				check_field("timer_drift_sum", e.timer_drift_sum, rsp.timer_drift_sum);
				check_field("all_drift_sum", e.all_drift_sum, rsp.all_drift_sum);
				check_field("active_count", e.active_count, rsp.active_count);
				check_field("last", e.last, rsp.last);
				if (e.kind == KIND_EXPIRY) n_fired++;
			end
		end
	end

	// one transfer; the model is updated at the accepting edge
	task automatic send_req(input htw_req_t q);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= q;
		do @(posedge clk); while (busy);
		predict_wheel(q);
		if (q.req_type != REQ_NONE) n_items++;
		if (q.req_type == REQ_TICK) n_ticks++;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	typedef struct {
		logic [1:0]  rt;
		logic [4:0]  id;
		logic [23:0] iv;
		logic        rp;
		bit          chk;
		logic [1:0]  st;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{REQ_START,  5'd0,  24'd0,        1'b0, 1, ST_BAD_START},
		'{REQ_START,  5'd31, 24'd1,        1'b0, 1, ST_OK},
		'{REQ_START,  5'd31, 24'd7,        1'b1, 1, ST_BAD_START},
		'{REQ_CANCEL, 5'd5,  24'd0,        1'b0, 1, ST_NOT_ACTIVE},
		'{REQ_START,  5'd1,  24'hFFFFFF,   1'b1, 1, ST_OK},
		'{REQ_START,  5'd2,  24'd2,        1'b1, 1, ST_OK},
		'{REQ_START,  5'd3,  24'd2,        1'b0, 1, ST_OK},
		'{REQ_START,  5'd4,  24'd64,       1'b0, 1, ST_OK},
		'{REQ_START,  5'd6,  24'd70,       1'b1, 1, ST_OK},
		'{REQ_TICK,   5'd0,  24'd0,        1'b0, 0, ST_OK},
		'{REQ_TICK,   5'd9,  24'd0,        1'b1, 0, ST_OK},
		'{REQ_NONE,   5'd3,  24'd5,        1'b1, 0, ST_OK},
		'{REQ_TICK,   5'd0,  24'd0,        1'b0, 0, ST_OK},
		'{REQ_START,  5'd5,  24'd3,        1'b0, 1, ST_OK},
		'{REQ_CANCEL, 5'd5,  24'd0,        1'b0, 1, ST_OK},
		'{REQ_CANCEL, 5'd1,  24'd0,        1'b0, 1, ST_OK},
		'{REQ_START,  5'd1,  24'd1,        1'b0, 1, ST_OK},
		'{REQ_START,  5'd16, 24'hAAAAAA,   1'b0, 1, ST_OK},
		'{REQ_START,  5'd15, 24'h555555,   1'b1, 1, ST_OK},
		'{REQ_TICK,   5'd0,  24'd0,        1'b0, 0, ST_OK},
		'{REQ_TICK,   5'd0,  24'd0,        1'b0, 0, ST_OK},
		'{REQ_CANCEL, 5'd3,  24'd0,        1'b0, 1, ST_NOT_ACTIVE}
	};

	initial begin
		htw_req_t q;
		int       pick;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		foreach (heads[i]) heads[i] = NIL;
		for (int i = 0; i < POOL; i++) begin
			nxt_of[i] = NIL; slot_of[i] = 0; deadline[i] = '0; armed_at[i] = '0;
			ivl_of[i] = '0; rep_of[i] = 1'b0; active[i] = 1'b0; fires[i] = '0;
			min_el[i] = '0; max_el[i] = '0; drift_of[i] = '0;
		end
		wheel_now = '0;
		n_armed = '0;
		drift_total = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			q = '{dir_rows[i].rt, dir_rows[i].id, dir_rows[i].iv, dir_rows[i].rp};
			send_req(q);
			if (dir_rows[i].chk && pending_rsp[$].status !== dir_rows[i].st) begin
				$error("row %0d status: expected %0d, predicted %0d", i,
					dir_rows[i].st, pending_rsp[$].status);
				errs++;
			end
		end
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 53;
				default: idle_pct = 7;
			endcase
			for (int k = 0; k < 80; k++) begin
				q = '0;
				q.timer_id = 5'($urandom_range(31));
				q.repeat_req = 1'($urandom_range(1));
				pick = $urandom_range(99);
				if (pick < 40) begin
					q.req_type = REQ_START;
					pick = $urandom_range(99);
					if (pick < 70) q.interval_ticks = 24'($urandom_range(80, 1));
					else if (pick < 85) q.interval_ticks = 24'($urandom_range(3000, 1));
					else if (pick < 90) q.interval_ticks = '0;
					else q.interval_ticks = 24'($urandom);
				end else if (pick < 55) begin
					q.req_type = REQ_CANCEL;
					q.interval_ticks = 24'($urandom);
				end else if (pick < 97) begin
					q.req_type = REQ_TICK;
					q.interval_ticks = 24'($urandom);
				end else begin
					q.req_type = REQ_NONE;
					q.interval_ticks = 24'($urandom);
					k--;
				end
				send_req(q);
			end
			// full stop before the next phase
			drain();
		end

		$display("%0d requests (%0d ticks, wheel at tick %0d), %0d results, %0d expiries",
			n_items, n_ticks, wheel_now, n_rsp, n_fired);
		if (errs == 0)
			$display("hierarchical_timer_wheel_top verification clean");
		else
			$display("hierarchical_timer_wheel_top verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("hierarchical_timer_wheel_top verification failed");
		$finish;
	end

endmodule

@@ hierarchical_timer_wheel_top.f @@
rtl/htw_pkg.sv
rtl/hierarchical_timer_wheel_top.sv
rtl/htw_checker.sv
sim/tb_hierarchical_timer_wheel_top.sv
